[design/fip_pkg.sv]
// Constants, register indexes and hash helpers shared by the index permutation.
`timescale 1ns / 1ps

package fip_pkg;

  // Multiplier and shift of the xor-shift-multiply round hash.
  localparam logic [31:0] MIX_MUL   = 32'h045d9f3b;
  localparam int unsigned MIX_SHIFT = 16;

  // Configuration register indexes.
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_COUNT = 1'b0;
  localparam cfg_idx_t CFG_KEY   = 1'b1;

  // Fold the upper half of the word into the lower half.
  function automatic logic [31:0] mix_fold(input logic [31:0] x);
    mix_fold = (x >> MIX_SHIFT) ^ x;
  endfunction

  // One fold and multiply step of the hash, kept modulo two to the 32.
  function automatic logic [31:0] mix_step(input logic [31:0] x);
    logic [31:0] f;
    f = mix_fold(x);
    mix_step = f * MIX_MUL;
  endfunction

endpackage

[design/feistel_index_permutation.sv]
// Keyed Feistel index permutation over a power-of-two domain, fully pipelined.
`timescale 1ns / 1ps
//
// Usage. Write count (index 0) and key (index 1) through cfg_we, cfg_index and
// cfg_data while no word is in flight. The domain width D is the bit width of
// count minus one, limited to MAX_DOMAIN_BITS, and is worked out as count is
// written. An index word is taken at each rising edge with start high and busy
// low; busy is high only during reset, so one word can enter in every cycle.
// Each index gives exactly one result word: value is its image under ROUNDS
// Feistel rounds, in_range tells whether value lies below count. The result
// appears on value and in_range with done high for a single cycle.
// The split stage registers the masked index cut into halves, each round registers
// its first hash multiply in stage a and the second in stage b, and the join stage
// joins the halves and compares with count. Throughput is one word per cycle;
// each round owns its pair of multipliers. Reset clears count, key and every valid
// bit, and words in flight are dropped. The receiver cannot stall, so no
// back-pressure exists and the pipeline never holds.
//
module feistel_index_permutation
  import fip_pkg::*;
#(
  parameter int ROUNDS          = 4,
  parameter int MAX_DOMAIN_BITS = 31
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [MAX_DOMAIN_BITS-1:0] index,
  output logic                       done,
  output logic [MAX_DOMAIN_BITS-1:0] value,
  output logic                       in_range,
  input  logic                       cfg_we,
  input  cfg_idx_t                   cfg_index,
  input  logic [31:0]                cfg_data
);

  localparam int DB   = MAX_DOMAIN_BITS;
  localparam int HALF = DB - DB / 2;
  localparam int DBW  = $clog2(DB + 1);
  localparam int LAT  = 2 * ROUNDS + 2;

  // Bit width of c minus one, saturated at the domain limit.
  function automatic logic [DBW-1:0] dom_bits(input logic [31:0] c);
    logic [31:0] m;
    int          b;
    m = c - 32'd1;
    b = 0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) begin
        b = i + 1;
      end
    end
    if (c == 32'd0) begin
      b = 0;
    end
    if (b > DB) begin
      b = DB;
    end
    dom_bits = DBW'(b);
  endfunction

  // Mask with the low n bits set, domain wide.
  function automatic logic [DB-1:0] mask_db(input logic [DBW-1:0] n);
    logic [DB-1:0] mk;
    for (int i = 0; i < DB; i++) begin
      mk[i] = (i < int'(n));
    end
    mask_db = mk;
  endfunction

  // Configuration registers and the domain figures derived from count.
  logic [31:0]    count;
  logic [31:0]    key;
  logic [DBW-1:0] wr0;
  logic [DBW-1:0] wr_fin;
  logic [DB-1:0]  mask_d;
  logic [HALF-1:0] mask_wl;
  logic [HALF-1:0] mask_wr;

  logic [DBW-1:0] d_next;
  logic [DBW-1:0] wr0_next;
  logic [DBW-1:0] wl0_next;
  logic [DB-1:0]  mask_wl_full;
  logic [DB-1:0]  mask_wr_full;

  always_comb begin
    d_next       = dom_bits(cfg_data);
    wr0_next     = d_next >> 1;
    wl0_next     = d_next - wr0_next;
    mask_wl_full = mask_db(wl0_next);
    mask_wr_full = mask_db(wr0_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      key     <= '0;
      wr0     <= '0;
      wr_fin  <= '0;
      mask_d  <= '0;
      mask_wl <= '0;
      mask_wr <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNT: begin
          count   <= cfg_data;
          wr0     <= wr0_next;
          wr_fin  <= (ROUNDS % 2 == 0) ? wr0_next : wl0_next;
          mask_d  <= mask_db(d_next);
          mask_wl <= mask_wl_full[HALF-1:0];
          mask_wr <= mask_wr_full[HALF-1:0];
        end
        CFG_KEY: begin
          key <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Input word handshake: the pipeline takes a word in every cycle outside reset.
  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // Split stage: mask the index to the domain and cut it into two halves.
  logic            vld0;
  logic [HALF-1:0] l0;
  logic [HALF-1:0] r0;
  logic [DB-1:0]   x_in;

  assign x_in = index & mask_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else begin
      vld0 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    l0 <= HALF'(x_in >> wr0);
    r0 <= HALF'(x_in) & mask_wr;
  end

  // Round pipeline: first hash multiply in stage a, second in stage b.
  logic            vld_in [ROUNDS+1];
  logic [HALF-1:0] l_in   [ROUNDS+1];
  logic [HALF-1:0] r_in   [ROUNDS+1];
  logic            vld_a  [ROUNDS];
  logic [HALF-1:0] la     [ROUNDS];
  logic [HALF-1:0] ra     [ROUNDS];
  logic [31:0]     ma     [ROUNDS];
  logic            vld_b  [ROUNDS];
  logic [HALF-1:0] lb     [ROUNDS];
  logic [HALF-1:0] rb     [ROUNDS];
  logic [31:0]     mb     [ROUNDS];

  assign vld_in[0] = vld0;
  assign l_in[0]   = l0;
  assign r_in[0]   = r0;

  for (genvar k = 0; k < ROUNDS; k++) begin : g_round
    logic [31:0]     h;
    logic [HALF-1:0] mask_k;

    // Valid bits of the round.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_a[k] <= 1'b0;
        vld_b[k] <= 1'b0;
      end else begin
        vld_a[k] <= vld_in[k];
        vld_b[k] <= vld_a[k];
      end
    end

    // Hash of the right half with round number and key, two multiplies.
    always_ff @(posedge clk) begin
      la[k] <= l_in[k];
      ra[k] <= r_in[k];
      ma[k] <= mix_step(32'(r_in[k]) ^ 32'(k) ^ key);
      lb[k] <= la[k];
      rb[k] <= ra[k];
      mb[k] <= mix_step(ma[k]);
    end

    // Finish the hash, mix it into the left half and swap the halves.
    assign mask_k      = (k % 2 == 0) ? mask_wl : mask_wr;
    assign h           = mix_fold(mb[k]);
    assign vld_in[k+1] = vld_b[k];
    assign l_in[k+1]   = rb[k];
    assign r_in[k+1]   = (lb[k] ^ h[HALF-1:0]) & mask_k;
  end

  // Join stage: rebuild the domain word and compare it with count.
  logic [DB-1:0] joined;

  assign joined = ((DB'(l_in[ROUNDS]) << wr_fin) | DB'(r_in[ROUNDS])) & mask_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_in[ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    value    <= joined;
    in_range <= (32'(joined) < count);
  end

  // Every accepted word gives one result word after the fixed latency.
  a_latency : assert property (@(posedge clk) disable iff (rst)
    done == $past(accept, LAT))
    else $error("result strobe does not follow an accepted word");

  // Reset empties the pipeline.
  a_reset_flush : assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  // A result never lies outside the domain width.
  a_domain : assert property (@(posedge clk) disable iff (rst)
    (done && $stable(mask_d) && $past(vld0) && !$past(cfg_we)) |->
      ((value & ~mask_d) == '0) || $past(cfg_we, 2))
    else $error("result word outside the domain");

endmodule

[sim/feistel_index_permutation_tb.sv]
// Self-checking testbench for the keyed Feistel index permutation.
`timescale 1ns / 1ps

module feistel_index_permutation_tb;
  import fip_pkg::*;

  localparam int ROUNDS      = 4;
  localparam int DBITS       = 31;
  localparam int LATENCY     = 2 * ROUNDS + 2;
  localparam int CYCLE_LIMIT = 400_000;

  // One index word waiting to be sent, with the idle cycles to spend before it.
  typedef struct {
    logic [DBITS-1:0] index;
    int unsigned      idle;
    bit               drain_first;
  } index_word_t;

  // One permuted index that the block should return.
  typedef struct {
    logic [DBITS-1:0] index;
    logic [DBITS-1:0] value;
    logic             in_range;
  } perm_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [DBITS-1:0] word_index = '0;
  logic             cfg_we = 1'b0;
  cfg_idx_t         cfg_index = CFG_COUNT;
  logic [31:0]      cfg_data = '0;
  logic             busy;
  logic             done;
  logic [DBITS-1:0] value;
  logic             in_range;

  index_word_t  word_queue[$];
  perm_result_t perm_expected[$];
  logic [31:0]  model_count = '0;
  logic [31:0]  model_key = '0;
  int unsigned  idle_count = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;

  feistel_index_permutation #(
    .ROUNDS          (ROUNDS),
    .MAX_DOMAIN_BITS (DBITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .index     (word_index),
    .done      (done),
    .value     (value),
    .in_range  (in_range),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Mask of the lowest n bits of a 32-bit word.
  function automatic logic [31:0] low_bits(input int unsigned n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  // Width of the permuted domain: bit width of count minus one, saturated.
  function automatic int unsigned span_bits(input logic [31:0] c);
    logic [31:0] m;
    int unsigned b;
    b = 0;
    if (c == 32'd0) return 0;
    m = c - 32'd1;
    while (m != 32'd0) begin
      b++;
      m = m >> 1;
    end
    return (b > DBITS) ? DBITS : b;
  endfunction

  // Xor-shift-multiply round hash, everything kept modulo two to the 32.
  function automatic logic [31:0] round_hash(input logic [31:0] x);
    logic [31:0] h;
    h = x;
    h = ((h >> MIX_SHIFT) ^ h) * MIX_MUL;
    h = ((h >> MIX_SHIFT) ^ h) * MIX_MUL;
    return (h >> MIX_SHIFT) ^ h;
  endfunction

  // Image of one index under the unbalanced Feistel rounds at the current setting.
  function automatic void feistel_image(input logic [DBITS-1:0] idx,
                                        output logic [DBITS-1:0] img,
                                        output logic ok);
    int unsigned bits, wl, wr, t;
    logic [31:0] x, l, r, nl, nr, rnd, y;
    bits = span_bits(model_count);
    wl   = bits - bits / 2;
    wr   = bits / 2;
    x    = {1'b0, idx} & low_bits(bits);
    l    = x >> wr;
    r    = x & low_bits(wr);
    for (rnd = 0; rnd < ROUNDS; rnd++) begin
      nl = r;
      nr = (l ^ round_hash(r ^ rnd ^ model_key)) & low_bits(wl);
      l  = nl;
      r  = nr;
      t  = wl;
      wl = wr;
      wr = t;
    end
    y   = ((l << wr) | r) & low_bits(bits);
    img = y[DBITS-1:0];
    ok  = (y < model_count);
  endfunction

  // Driver: predicts each accepted word and launches the next one after its idle gap.
  always @(posedge clk) begin : word_driver
    logic fire, next_start;
    perm_result_t res;
    fire = start && !busy;
    next_start = 1'b0;
    if (rst) begin
      start      <= 1'b0;
      idle_count <= 0;
    end else begin
      if (fire) begin
        res.index = word_index;
        feistel_image(word_index, res.value, res.in_range);
        perm_expected.push_back(res);
      end
      next_start = start && !fire;
      if (!next_start && word_queue.size() != 0) begin
        // A draining word waits until every earlier result has come back.
        if (!(word_queue[0].drain_first && perm_expected.size() != 0)) begin
          if (idle_count < word_queue[0].idle) begin
            idle_count <= idle_count + 1;
          end else begin
            word_index <= word_queue[0].index;
            idle_count <= 0;
            next_start = 1'b1;
            void'(word_queue.pop_front());
          end
        end
      end
      start <= next_start;
    end
  end

  // Monitor: each result word is checked against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    perm_result_t want;
    if (!rst && done) begin
      if (perm_expected.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: result with none expected: value=%h in_range=%b",
                   value, in_range);
        mismatches++;
      end else begin
        want = perm_expected.pop_front();
        if (value !== want.value || in_range !== want.in_range) begin
          if (mismatches < 10)
            $display("ERROR: index %h: value %h/%h in_range %b/%b (expected/actual)",
                     want.index, want.value, value, want.in_range, in_range);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add_word(input logic [DBITS-1:0] idx, input int unsigned idle,
                          input bit drain_first);
    index_word_t w;
    w.index       = idx;
    w.idle        = idle;
    w.drain_first = drain_first;
    word_queue.push_back(w);
  endtask

  // Wait until no word is queued, in flight or owed, then let the pipeline settle.
  task automatic wait_idle();
    while (word_queue.size() != 0 || start || perm_expected.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_COUNT) model_count = data;
    else model_key = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] c, input logic [31:0] k);
    wait_idle();
    write_reg(CFG_COUNT, c);
    write_reg(CFG_KEY, k);
    @(negedge clk);
  endtask

  // Random indices, mostly inside the domain, with idle-free stretches.
  task automatic add_random(input int unsigned n, input bit burst);
    logic [31:0] idx;
    int unsigned idle;
    for (int unsigned i = 0; i < n; i++) begin
      idx = $urandom();
      if ($urandom_range(3, 0) != 0) idx = idx & low_bits(span_bits(model_count));
      idle = (burst || (i % 40) < 8) ? 0 : $urandom_range(18, 0);
      add_word(idx[DBITS-1:0], idle, i == n / 2);
    end
  endtask

  initial begin : stimulus
    int unsigned d;
    logic [31:0] c, k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Count zero straight after reset: nothing is in range.
    @(negedge clk);
    add_word(31'h0000_0000, 0, 0);
    add_word(31'h7FFF_FFFF, 0, 0);
    add_word(31'h5555_5555, 3, 0);
    add_word(31'h2AAA_AAAA, 0, 0);

    // Count one: empty domain, the single value is in range.
    set_regs(32'd1, 32'd0);
    add_word(31'h0000_0000, 0, 0);
    add_word(31'h7FFF_FFFF, 2, 0);

    // One-bit domain; upper index bits must be ignored.
    set_regs(32'd2, 32'hFFFF_FFFF);
    add_word(31'h0000_0000, 0, 0);
    add_word(31'h0000_0001, 0, 0);
    add_word(31'h7FFF_FFFE, 5, 0);
    add_word(31'h7FFF_FFFF, 0, 0);

    // Widest domain: every value lies below count.
    set_regs(32'h8000_0000, 32'hFFFF_FFFF);
    add_word(31'h0000_0000, 0, 0);
    add_word(31'h7FFF_FFFF, 0, 0);
    add_word(31'h0000_0001, 1, 0);
    add_word(31'h4000_0000, 0, 0);
    add_word(31'h2AAA_AAAA, 0, 0);
    add_word(31'h5555_5555, 0, 0);

    // Count not a power of two, so in_range varies.
    set_regs(32'd1000, 32'h9E37_79B9);
    add_word(31'd0, 0, 0);
    add_word(31'd999, 0, 0);
    add_word(31'd1000, 4, 0);
    add_word(31'd1023, 0, 0);
    add_word(31'd1024, 0, 0);
    add_word(31'h7FFF_FFFF, 0, 0);

    // Random settings, each followed by a batch of random words.
    for (int ph = 0; ph < 10; ph++) begin
      d = $urandom_range(31, 0);
      case ($urandom_range(9, 0))
        0:       c = 32'd0;
        1:       c = 32'h8000_0000;
        default: c = (d == 0) ? $urandom_range(1, 0)
                              : $urandom_range(32'd1 << d, (32'd1 << (d - 1)) + 1);
      endcase
      case ($urandom_range(5, 0))
        0:       k = 32'd0;
        1:       k = 32'hFFFF_FFFF;
        default: k = $urandom();
      endcase
      set_regs(c, k);
      add_random(150, $urandom_range(2, 0) == 0);
    end

    wait_idle();
    if (mismatches == 0 && perm_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
